// File: rtl/mcpa_pkg.sv
`default_nettype none
package mcpa_pkg;
  localparam int unsigned POOL_BYTES = 33554432;
  localparam int unsigned SLOT_COUNT = 32;
  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned PW = $clog2(POOL_BYTES + 1);
  localparam logic [PW-1:0] POOL_SZ = PW'(POOL_BYTES);

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_MARK = 2'd1;
  localparam logic [1:0] FN_COLLECT = 2'd2;

  localparam logic [2:0] K_ALLOC = 3'd0;
  localparam logic [2:0] K_MARK = 3'd1;
  localparam logic [2:0] K_MOVED = 3'd2;
  localparam logic [2:0] K_FREED = 3'd3;
  localparam logic [2:0] K_DONE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BIG = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] status;
    logic [4:0] slot_id;
    logic [24:0] old_address;
    logic [24:0] new_address;
    logic [25:0] length;
    logic [5:0] live_count;
    logic [25:0] free_bytes;
    logic [25:0] reclaimed_bytes;
    logic last;
  } res_t;

  typedef enum logic [3:0] {
    C_NONE, C_LATCH, C_GC_START, C_GC_RD, C_GC_STEP, C_GC_END,
    C_ALLOC, C_MARK, C_EMIT_BIG, C_EMIT_FULL, C_EMIT_NOSP, C_EMIT_DONE
  } cmd_t;

  typedef struct packed {
    logic gc_more;
    logic fits;
    logic too_big;
    logic have_free;
    logic emit;
    logic [1:0] func;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/mark_compact_pool_allocator.sv
`default_nettype none
// Mark-compact pool allocator: one input word (alloc, mark, collect) at a time.
// A mark result is formed in S_DEC, and an alloc that fits in S_AFT after it; each
// is registered in the datapath and then raises out_tvalid. The input reopens
// the cycle after the result word is taken. A collection walks the live slots
// in address order through the single-port slot tables, going through S_GA,
// S_GR and S_GX for each slot, and holds in S_GA while a move or free word is
// still pending at the output. Each result word waits in the output register.
module mark_compact_pool_allocator (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [31:0] in_tdata, // func[1:0], object_size[26:2], handle[31:27]
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [167:0] out_tdata, // kind, status, slot_id, old_address, new_address,
                                  // length, live_count, free_bytes, reclaimed_bytes
  output logic out_tlast
);
  import mcpa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic vld_r;
  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  mcpa_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_func(in_tdata[1:0]), .out_busy(vld_r || sts.emit),
    .sts, .in_ready(in_tready), .cmd
  );

  mcpa_datapath u_dp (
    .clk, .rst_n, .cmd, .in_func(in_tdata[1:0]), .in_size(in_tdata[26:2]),
    .in_handle(in_tdata[31:27]), .sts, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (sts.emit) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
  end

  assign out_tvalid = vld_r;
  assign out_tlast = res.last;
  assign out_tdata = {24'd0, res.reclaimed_bytes, res.free_bytes, res.live_count,
                      res.length, res.new_address, res.old_address, res.slot_id,
                      res.status, res.kind};
endmodule
`default_nettype wire

// File: rtl/mcpa_datapath.sv
`default_nettype none
module mcpa_datapath (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mcpa_pkg::cmd_t cmd,
  input  wire logic [1:0] in_func,
  input  wire logic [24:0] in_size,
  input  wire logic [4:0] in_handle,
  output mcpa_pkg::sts_t sts,
  output mcpa_pkg::res_t res
);
  import mcpa_pkg::*;

  logic [24:0] start_mem [SLOT_COUNT];
  logic [25:0] fp_mem [SLOT_COUNT];
  logic [SW-1:0] order_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] marked_r, in_use_r;
  logic [CW-1:0] order_cnt_r, idx_r, wr_r;
  logic [PW-1:0] free_ptr_r, recl_r, gc_fp_r;
  logic [1:0] func_r;
  logic [25:0] fp_need_r;
  logic [4:0] handle_r;
  logic [SW-1:0] cur_s_r, free_slot;
  logic [24:0] cur_start_r;
  logic [25:0] cur_len_r;
  logic have_free;
  logic [PW-1:0] space;
  logic emit_r;
  res_t res_r;
  res_t res_nxt;
  logic emit_nxt, mark_ok, moved;

  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        have_free = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  assign space = (free_ptr_r >= POOL_SZ) ? '0 : POOL_SZ - free_ptr_r;
  assign sts.gc_more = (idx_r < order_cnt_r);
  assign sts.fits = ({6'd0, space} >= 32'(fp_need_r));
  assign sts.too_big = (32'(fp_need_r) > 32'(POOL_SZ));
  assign sts.have_free = have_free && (order_cnt_r < CW'(SLOT_COUNT));
  assign sts.emit = emit_r;
  assign sts.func = func_r;
  assign res = res_r;

  assign mark_ok = in_use_r[handle_r];
  assign moved = (PW'(cur_start_r) != gc_fp_r);

  always_comb begin
    res_nxt = '0;
    emit_nxt = 1'b0;
    unique case (cmd)
      C_GC_STEP: begin
        res_nxt.slot_id = 5'(cur_s_r);
        res_nxt.length = cur_len_r;
        if (!marked_r[cur_s_r]) begin
          res_nxt.kind = K_FREED;
          emit_nxt = 1'b1;
        end else if (moved) begin
          res_nxt.kind = K_MOVED;
          res_nxt.old_address = cur_start_r;
          res_nxt.new_address = 25'(gc_fp_r);
          emit_nxt = 1'b1;
        end
      end
      C_ALLOC: begin
        res_nxt.kind = K_ALLOC;
        res_nxt.status = ST_OK;
        res_nxt.slot_id = 5'(free_slot);
        res_nxt.new_address = 25'(free_ptr_r);
        res_nxt.live_count = 6'(order_cnt_r + 1'b1);
        res_nxt.free_bytes = 26'(space - PW'(fp_need_r));
        res_nxt.last = 1'b1;
        emit_nxt = 1'b1;
      end
      C_MARK: begin
        res_nxt.kind = K_MARK;
        res_nxt.status = mark_ok ? ST_OK : ST_FULL;
        res_nxt.slot_id = handle_r;
        res_nxt.live_count = 6'(order_cnt_r);
        res_nxt.free_bytes = 26'(space);
        res_nxt.last = 1'b1;
        emit_nxt = 1'b1;
      end
      C_EMIT_BIG, C_EMIT_FULL, C_EMIT_NOSP, C_EMIT_DONE: begin
        res_nxt.kind = (cmd == C_EMIT_DONE) ? K_DONE : K_ALLOC;
        res_nxt.status = (cmd == C_EMIT_BIG) ? ST_BIG :
                         (cmd == C_EMIT_FULL) ? ST_FULL :
                         (cmd == C_EMIT_NOSP) ? ST_NOSPACE : ST_OK;
        res_nxt.live_count = 6'(order_cnt_r);
        res_nxt.free_bytes = 26'(space);
        res_nxt.reclaimed_bytes = (cmd == C_EMIT_DONE) ? 26'(recl_r) : 26'd0;
        res_nxt.last = 1'b1;
        emit_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_s_r <= order_mem[idx_r[SW-1:0]];
    if (!rst_n) begin
      marked_r <= '0;
      in_use_r <= '0;
      order_cnt_r <= '0;
      free_ptr_r <= '0;
      idx_r <= '0;
      wr_r <= '0;
      recl_r <= '0;
      emit_r <= 1'b0;
    end else begin
      emit_r <= emit_nxt;
      if (emit_nxt) res_r <= res_nxt;
      unique case (cmd)
        C_LATCH: begin
          func_r <= in_func;
          fp_need_r <= 26'(in_size) + 26'd1;
          handle_r <= in_handle;
          recl_r <= '0;
        end
        C_GC_START: begin
          idx_r <= '0;
          wr_r <= '0;
          gc_fp_r <= '0;
        end
        C_GC_RD: begin
          cur_start_r <= start_mem[cur_s_r];
          cur_len_r <= fp_mem[cur_s_r];
        end
        C_GC_STEP: begin
          idx_r <= idx_r + 1'b1;
          if (marked_r[cur_s_r]) begin
            marked_r[cur_s_r] <= 1'b0;
            if (moved) start_mem[cur_s_r] <= 25'(gc_fp_r);
            gc_fp_r <= gc_fp_r + PW'(cur_len_r);
            order_mem[wr_r[SW-1:0]] <= cur_s_r;
            wr_r <= wr_r + 1'b1;
          end else begin
            recl_r <= recl_r + PW'(cur_len_r);
            in_use_r[cur_s_r] <= 1'b0;
          end
        end
        C_GC_END: begin
          order_cnt_r <= wr_r;
          free_ptr_r <= gc_fp_r;
        end
        C_ALLOC: begin
          in_use_r[free_slot] <= 1'b1;
          marked_r[free_slot] <= 1'b0;
          start_mem[free_slot] <= 25'(free_ptr_r);
          fp_mem[free_slot] <= fp_need_r;
          order_mem[order_cnt_r[SW-1:0]] <= free_slot;
          order_cnt_r <= order_cnt_r + 1'b1;
          free_ptr_r <= free_ptr_r + PW'(fp_need_r);
        end
        C_MARK: begin
          if (mark_ok) marked_r[handle_r] <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/mcpa_ctrl.sv
`default_nettype none
module mcpa_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic [1:0] in_func,
  input  wire logic out_busy,
  input  wire mcpa_pkg::sts_t sts,
  output logic in_ready,
  output mcpa_pkg::cmd_t cmd
);
  import mcpa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_GS = 4'd2, S_GA = 4'd3,
                         S_GR = 4'd4, S_GX = 4'd5, S_GE = 4'd6, S_AFT = 4'd7,
                         S_WAIT = 4'd8, S_FIN = 4'd9;
  logic [3:0] st_r, st_nxt;

  assign in_ready = (st_r == S_IDLE) && !out_busy;

  always_comb begin
    st_nxt = st_r;
    cmd = C_NONE;
    unique case (st_r)
      S_IDLE: if (in_fire && in_func != 2'd3) begin
        cmd = C_LATCH;
        st_nxt = S_DEC;
      end
      S_DEC: begin
        priority case (sts.func)
          FN_MARK: begin
            cmd = C_MARK;
            st_nxt = S_WAIT;
          end
          FN_COLLECT: st_nxt = S_GS;
          default: begin
            if (sts.too_big) begin
              cmd = C_EMIT_BIG;
              st_nxt = S_WAIT;
            end else if (!sts.fits) st_nxt = S_GS;
            else st_nxt = S_AFT;
          end
        endcase
      end
      S_GS: begin
        cmd = C_GC_START;
        st_nxt = S_GA;
      end
      S_GA: if (!out_busy) begin
        if (sts.gc_more) st_nxt = S_GR;
        else st_nxt = S_GE;
      end
      S_GR: begin
        cmd = C_GC_RD;
        st_nxt = S_GX;
      end
      S_GX: begin
        cmd = C_GC_STEP;
        st_nxt = S_GA;
      end
      S_GE: begin
        cmd = C_GC_END;
        st_nxt = S_FIN;
      end
      S_FIN: if (!out_busy) begin
        st_nxt = S_WAIT;
        cmd = (sts.func == FN_COLLECT) ? C_EMIT_DONE : C_NONE;
        if (sts.func != FN_COLLECT) st_nxt = S_AFT;
      end
      S_AFT: if (!out_busy) begin
        st_nxt = S_WAIT;
        if (!sts.have_free) cmd = C_EMIT_FULL;
        else if (!sts.fits) cmd = C_EMIT_NOSP;
        else cmd = C_ALLOC;
      end
      S_WAIT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/mcpa_checker.sv
`default_nettype none
module mcpa_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [167:0] out_tdata,
  input wire logic out_tlast
);
  import mcpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled word changed");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= K_DONE) else $error("bad kind");
  a_nolast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == K_MOVED || out_tdata[2:0] == K_FREED) |-> !out_tlast)
    else $error("move/free marked last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
endmodule
bind mark_compact_pool_allocator mcpa_props u_chk (.*);
`default_nettype wire
